>>> hw/rtl/assert_macros.svh
// Assertion macros for the compensation RTL, used by baro_back.
// Depends on nothing; empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/baro_pkg.sv
// Types and constants for the barometric compensation core.
// No dependencies.
package baro_pkg;
  localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW = 2'd1;
  localparam logic [1:0] REG_PRESS_MID = 2'd2;
  localparam logic [1:0] REG_PRESS_P9  = 2'd3;
  localparam int unsigned CfgIdxW = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] sample_msb;
    logic [7:0] sample_lsb;
    logic [7:0] sample_xlsb;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_hpa;
    logic        divisor_zero;
  } out_item_t;

  // queued command between front and back
  typedef struct packed {
    logic        kind;
    logic [19:0] adc;
  } cmd_t;
endpackage

>>> hw/rtl/baro_front.sv
// Front end: accepts items, assembles the 20-bit sample, two-entry queue.
// Depends on baro_pkg.
module baro_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  baro_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output baro_pkg::cmd_t    cmd_o
);
  import baro_pkg::*;
  cmd_t mem_q [2];
  logic wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q ^ push;
    rp_d = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{kind: in_item_i.kind,
                       adc: {in_item_i.sample_msb, in_item_i.sample_lsb,
                             in_item_i.sample_xlsb[7:4]}};
    end
  end
endmodule

>>> hw/rtl/baro_div.sv
// Serial restoring divider, 64-bit unsigned magnitudes, one bit a cycle.
// No dependencies.
module baro_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  assign trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0; quo_d = num_i; cnt_d = 7'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]}; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end
endmodule

>>> hw/rtl/baro_back.sv
// Back end: microcoded sequencer with one 32x32 multiplier and a serial divider.
// Depends on baro_pkg and baro_div; includes assert_macros.svh.
`include "assert_macros.svh"
module baro_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  baro_pkg::cmd_t     cmd_i,
  input  logic [47:0]        temp_cal_i,
  input  logic [63:0]        press_low_i,
  input  logic [63:0]        press_mid_i,
  input  logic [15:0]        press_p9_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output baro_pkg::out_item_t out_item_o
);
  import baro_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_T0 = 6'd1, S_T1 = 6'd2, S_T2 = 6'd3, S_T3 = 6'd4;
  localparam logic [5:0] S_T4 = 6'd5, S_T5 = 6'd6;
  localparam logic [5:0] S_P0 = 6'd7, S_P1 = 6'd8, S_P2 = 6'd9, S_P3 = 6'd10;
  localparam logic [5:0] S_P4 = 6'd11, S_P5 = 6'd12, S_P6 = 6'd13, S_P7 = 6'd14;
  localparam logic [5:0] S_P8 = 6'd15, S_P9 = 6'd16, S_P10 = 6'd17;
  localparam logic [5:0] S_DIV1 = 6'd18, S_W1 = 6'd19, S_P11 = 6'd20;
  localparam logic [5:0] S_P12 = 6'd21, S_P13 = 6'd22, S_P14 = 6'd23;
  localparam logic [5:0] S_DIV2 = 6'd24, S_W2 = 6'd25, S_OUT = 6'd26;
  localparam logic [5:0] S_MUL = 6'd27;

  // ceil(2^26 / 25): exact quotient by 25 for any dividend below 25 * 2^16
  localparam logic [21:0] RECIP_25 = 22'd2684355;

  logic [5:0]  st_q, st_d, ret_q, ret_d;
  logic [1:0]  mph_q, mph_d;
  logic [63:0] ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [63:0] a_q, a_d, b_q, b_d, c_q, c_d, pv_q, pv_d;
  logic [31:0] fine_q, fine_d;
  logic [19:0] adc_q, adc_d;
  logic        neg_q, neg_d;
  out_item_t   res_q, res_d;
  logic        ov_q, ov_d;
  logic        dstart;
  logic [63:0] dnum, dden, dquo;
  logic        ddone;
  logic [4:0]  r25_q, r25_d;
  logic [1:0]  dig_q, dig_d;

  // one 32x32 partial product per cycle; their sum wraps to a 64-bit product
  logic [31:0] pa, pb;
  logic [63:0] pp;
  always_comb begin
    case (mph_q)
      2'd0: begin pa = ma_q[31:0];  pb = mb_q[31:0];  end
      2'd1: begin pa = ma_q[63:32]; pb = mb_q[31:0];  end
      default: begin pa = ma_q[31:0]; pb = mb_q[63:32]; end
    endcase
  end
  assign pp = {32'd0, pa} * {32'd0, pb};

  // divide by 25600: drop ten bits, then one 16-bit digit by 25 per cycle
  logic [20:0] dx, dr;
  logic [42:0] dprod;
  logic [15:0] dq;
  assign dx    = {r25_q, c_q[63:48]};
  assign dprod = {22'd0, dx} * {21'd0, RECIP_25};
  assign dq    = dprod[41:26];
  assign dr    = dx - ({5'd0, dq} * 21'd25);

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction
  function automatic logic [63:0] asr(input logic [63:0] v, input int s);
    asr = $signed(v) >>> s;
  endfunction

  baro_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
                  .done_o(ddone), .quo_o(dquo));

  assign cmd_ready_o = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o  = res_q;

  logic [31:0] t1, t2, t3;
  logic [63:0] mag_a, mag_b;
  assign t1 = {16'd0, temp_cal_i[15:0]};
  assign t2 = {{16{temp_cal_i[31]}}, temp_cal_i[31:16]};
  assign t3 = {{16{temp_cal_i[47]}}, temp_cal_i[47:32]};
  assign mag_a = a_q[63] ? 64'd0 - a_q : a_q;
  assign mag_b = b_q[63] ? 64'd0 - b_q : b_q;

  always_comb begin
    st_d = st_q; ret_d = ret_q; mph_d = mph_q; ma_d = ma_q; mb_d = mb_q;
    acc_d = acc_q; a_d = a_q; b_d = b_q; c_d = c_q; pv_d = pv_q;
    fine_d = fine_q; adc_d = adc_q; neg_d = neg_q;
    r25_d = r25_q; dig_d = dig_q;
    res_d = res_q; ov_d = ov_q; dstart = 1'b0; dnum = mag_a; dden = mag_b;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: if (cmd_valid_i) begin
        adc_d = cmd_i.adc;
        st_d = cmd_i.kind ? S_P0 : S_T0;
      end
      S_MUL: begin
        // accumulate partial products, hold product in acc
        case (mph_q)
          2'd0: acc_d = pp;
          default: acc_d = acc_q + {pp[31:0], 32'd0};
        endcase
        mph_d = mph_q + 2'd1;
        if (mph_q == 2'd2) st_d = ret_q;
      end
      // temperature: a=adc>>3-2T1; v1 = (a*T2)>>>11
      S_T0: begin
        ma_d = {32'd0, {15'd0, adc_q[19:3]} - {t1[30:0], 1'b0}};
        mb_d = {32'd0, t2}; mph_d = 2'd0; ret_d = S_T1; st_d = S_MUL;
      end
      S_T1: begin
        a_d = {32'd0, 32'($signed(acc_q[31:0]) >>> 11)};
        ma_d = {32'd0, {16'd0, adc_q[19:4]} - t1};
        mb_d = {32'd0, {16'd0, adc_q[19:4]} - t1};
        mph_d = 2'd0; ret_d = S_T2; st_d = S_MUL;
      end
      S_T2: begin
        ma_d = {32'd0, 32'($signed(acc_q[31:0]) >>> 12)};
        mb_d = {32'd0, t3}; mph_d = 2'd0; ret_d = S_T3; st_d = S_MUL;
      end
      S_T3: begin
        fine_d = a_q[31:0] + 32'($signed(acc_q[31:0]) >>> 14);
        st_d = S_T4;
      end
      S_T4: begin
        b_d = {32'd0, 32'($signed(fine_q * 32'd5 + 32'd128) >>> 8)};
        st_d = S_T5;
      end
      S_T5: if (!ov_q || out_ready_i) begin
        res_d = '{result_kind: 1'b0, temperature_centi: b_q[31:0],
                  pressure_hpa: 32'd0, divisor_zero: 1'b0};
        ov_d = 1'b1; st_d = S_IDLE;
      end
      // pressure
      S_P0: begin
        c_d = {{32{fine_q[31]}}, fine_q} - 64'd128000;
        st_d = S_P1;
      end
      S_P1: begin ma_d = c_q; mb_d = c_q; mph_d = 2'd0; ret_d = S_P2; st_d = S_MUL; end
      S_P2: begin
        pv_d = acc_q; // v1*v1
        ma_d = acc_q; mb_d = sx16(press_mid_i[31:16]);
        mph_d = 2'd0; ret_d = S_P3; st_d = S_MUL;
      end
      S_P3: begin
        a_d = acc_q + (sx16(press_low_i[63:48]) << 35); // v2 partial
        ma_d = c_q; mb_d = sx16(press_mid_i[15:0]);
        mph_d = 2'd0; ret_d = S_P4; st_d = S_MUL;
      end
      S_P4: begin
        a_d = a_q + (acc_q << 17);
        ma_d = pv_q; mb_d = sx16(press_low_i[47:32]);
        mph_d = 2'd0; ret_d = S_P5; st_d = S_MUL;
      end
      S_P5: begin
        b_d = asr(acc_q, 8);
        ma_d = c_q; mb_d = sx16(press_low_i[31:16]);
        mph_d = 2'd0; ret_d = S_P6; st_d = S_MUL;
      end
      S_P6: begin
        ma_d = (64'd1 << 47) + b_q + (acc_q << 12);
        mb_d = {48'd0, press_low_i[15:0]};
        mph_d = 2'd0; ret_d = S_P7; st_d = S_MUL;
      end
      S_P7: begin
        b_d = asr(acc_q, 33);
        st_d = S_P8;
      end
      S_P8: begin
        // leave the result register alone: an earlier item may still wait there
        if (b_q == 64'd0) begin
          st_d = S_P9;
        end else begin
          ma_d = ((64'd1048576 - {44'd0, adc_q}) << 31) - a_q;
          mb_d = 64'd3125; mph_d = 2'd0; ret_d = S_P10; st_d = S_MUL;
        end
      end
      S_P9: if (!ov_q || out_ready_i) begin
        res_d = '{result_kind: 1'b1, temperature_centi: 32'd0,
                  pressure_hpa: 32'd0, divisor_zero: 1'b1};
        ov_d = 1'b1; st_d = S_IDLE;
      end
      S_P10: begin a_d = acc_q; st_d = S_DIV1; end
      S_DIV1: begin
        dstart = 1'b1; neg_d = a_q[63] ^ b_q[63]; st_d = S_W1;
      end
      S_W1: if (ddone) begin
        pv_d = neg_q ? 64'd0 - dquo : dquo; st_d = S_P11;
      end
      S_P11: begin
        ma_d = sx16(press_p9_i); mb_d = asr(pv_q, 13);
        mph_d = 2'd0; ret_d = S_P12; st_d = S_MUL;
      end
      S_P12: begin
        c_d = asr(acc_q, 25);
        ma_d = sx16(press_mid_i[63:48]); mb_d = pv_q;
        mph_d = 2'd0; ret_d = S_P13; st_d = S_MUL;
      end
      S_P13: begin
        a_d = asr(pv_q + c_q + asr(acc_q, 19), 8) + (sx16(press_mid_i[47:32]) << 4);
        st_d = S_P14;
      end
      S_P14: begin
        // magnitude over 1024, then four digits over 25
        c_d = {10'd0, mag_a[63:10]}; pv_d = '0; r25_d = '0; dig_d = '0;
        neg_d = a_q[63]; st_d = S_DIV2;
      end
      S_DIV2: begin
        pv_d = {pv_q[47:0], dq}; c_d = {c_q[47:0], 16'd0};
        r25_d = dr[4:0]; dig_d = dig_q + 2'd1;
        if (dig_q == 2'd3) st_d = S_W2;
      end
      S_W2: begin
        pv_d = neg_q ? 64'd0 - pv_q : pv_q; st_d = S_OUT;
      end
      S_OUT: if (!ov_q || out_ready_i) begin
        res_d = '{result_kind: 1'b1, temperature_centi: 32'd0,
                  pressure_hpa: pv_q[31:0], divisor_zero: 1'b0};
        ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_IDLE; mph_q <= 2'd0; fine_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; mph_q <= mph_d; fine_q <= fine_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q <= ma_d; mb_q <= mb_d; acc_q <= acc_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; pv_q <= pv_d;
    adc_q <= adc_d; neg_q <= neg_d; res_q <= res_d;
    r25_q <= r25_d; dig_q <= dig_d;
  end

  `ASSERT_IMPL(a_take_idle, clk_i, rst_ni, (cmd_valid_i && cmd_ready_o) |=> (st_q != S_IDLE))
  `ASSERT_IMPL(a_res_hold, clk_i, rst_ni, (ov_q && !out_ready_i) |=> (ov_q && $stable(res_q)))
  `ASSERT_NEVER(a_div_busy, clk_i, rst_ni, dstart && (st_q != S_DIV1))
endmodule

>>> hw/rtl/baro_sensor_compensation_core.sv
// Barometric compensation core: front queue, microcoded back end, serial divider.
// Temperature results come from serial partial-product multiplies; pressure results
// add a serial divide and 4 digits over 25; a zero divisor ends before the divide.
// The back end takes a new item only after its result enters the output register,
// held off while an earlier result waits unaccepted; the front queue holds two items.
// Reset: asynchronous active low; calibration and fine temperature clear to 0.
module baro_sensor_compensation_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  baro_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output baro_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);
  import baro_pkg::*;
  logic [47:0] temp_cal_q;
  logic [63:0] press_low_q, press_mid_q;
  logic [15:0] press_p9_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // calibration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0; press_low_q <= '0; press_mid_q <= '0; press_p9_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_CAL:  temp_cal_q  <= cfg_data_i[47:0];
        REG_PRESS_LOW: press_low_q <= cfg_data_i;
        REG_PRESS_MID: press_mid_q <= cfg_data_i;
        REG_PRESS_P9:  press_p9_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  baro_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
                      .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd));

  baro_back u_back (.clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
                    .cmd_i(cmd), .temp_cal_i(temp_cal_q), .press_low_i(press_low_q),
                    .press_mid_i(press_mid_q), .press_p9_i(press_p9_q),
                    .out_valid_o, .out_ready_i, .out_item_o);
endmodule

>>> tb/baro_sensor_compensation_core_test.sv
// Self-checking testbench for the barometric compensation core.
// Depends on baro_pkg and baro_sensor_compensation_core; predicts every item
// in a scoreboard class and drives the block through plain tasks.
module baro_sensor_compensation_core_test;
  import baro_pkg::*;

  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;
  localparam int   DRAIN_CYCLES = 400;

  // Calibration and fine temperature in one place; predicts one result per item.
  class comp_scoreboard;
    logic [63:0] cal [4];
    logic [31:0] t_fine;
    out_item_t   pending [$];
    int          errors;
    int          n_temp, n_press, n_zero;

    function new();
      foreach (cal[i]) cal[i] = '0;
      t_fine = '0;
      errors = 0;
      n_temp = 0;
      n_press = 0;
      n_zero = 0;
    endfunction

    function void write_cal(logic [1:0] idx, logic [63:0] data);
      case (idx)
        REG_TEMP_CAL:  cal[idx] = {16'h0, data[47:0]};
        REG_PRESS_P9:  cal[idx] = {48'h0, data[15:0]};
        default:       cal[idx] = data;
      endcase
    endfunction

    function automatic logic [31:0] asr32(logic [31:0] v, int s);
      return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int s);
      return 64'($signed(v) >>> s);
    endfunction

    // signed divide, truncating toward zero, on magnitudes
    function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q  = ma / mb;
      return (a[63] ^ b[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] centi_degrees(logic [19:0] adc);
      logic [31:0] t1, t2, t3, x, lin, d, quad;
      t1 = {16'h0, cal[REG_TEMP_CAL][15:0]};
      t2 = {{16{cal[REG_TEMP_CAL][31]}}, cal[REG_TEMP_CAL][31:16]};
      t3 = {{16{cal[REG_TEMP_CAL][47]}}, cal[REG_TEMP_CAL][47:32]};
      x    = {12'h0, adc} >> 3;
      x    = x - (t1 << 1);
      lin  = asr32(x * t2, 11);
      d    = ({12'h0, adc} >> 4) - t1;
      quad = asr32(asr32(d * d, 12) * t3, 14);
      t_fine = lin + quad;
      return asr32(t_fine * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [31:0] hpa(logic [19:0] adc, output logic zero);
      logic [63:0] p [1:9];
      logic [63:0] a, b, pa;
      p[1] = {48'h0, cal[REG_PRESS_LOW][15:0]};
      for (int i = 1; i < 4; i++)
        p[i+1] = {{48{cal[REG_PRESS_LOW][16*i+15]}}, cal[REG_PRESS_LOW][16*i +: 16]};
      for (int i = 0; i < 4; i++)
        p[i+5] = {{48{cal[REG_PRESS_MID][16*i+15]}}, cal[REG_PRESS_MID][16*i +: 16]};
      p[9] = {{48{cal[REG_PRESS_P9][15]}}, cal[REG_PRESS_P9][15:0]};
      a = {{32{t_fine[31]}}, t_fine} - 64'd128000;
      b = a * a * p[6];
      b = b + ((a * p[5]) << 17);
      b = b + (p[4] << 35);
      a = asr64(a * a * p[3], 8) + ((a * p[2]) << 12);
      a = asr64(((64'd1 << 47) + a) * p[1], 33);
      // Zero divisor: force the result and flag it
      if (a == 0) begin
        zero = 1'b1;
        return '0;
      end
      zero = 1'b0;
      pa = 64'd1048576 - {44'h0, adc};
      pa = sdiv(((pa << 31) - b) * 64'd3125, a);
      a  = asr64(p[9] * asr64(pa, 13), 25);
      b  = asr64(p[8] * pa, 19);
      pa = asr64(pa + a + b, 8) + (p[7] << 4);
      return 32'(sdiv(pa, 64'd25600));
    endfunction

    // Note an accepted input item and queue its expected result.
    function void note_input(in_item_t it);
      out_item_t   r;
      logic [19:0] adc;
      logic        zero;
      adc = {it.sample_msb, it.sample_lsb, it.sample_xlsb[7:4]};
      r = '0;
      r.result_kind = it.kind;
      if (it.kind == KIND_TEMP) begin
        r.temperature_centi = centi_degrees(adc);
        n_temp++;
      end else begin
        r.pressure_hpa = hpa(adc, zero);
        r.divisor_zero = zero;
        n_press++;
        if (zero) n_zero++;
      end
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    // Check an accepted result against the oldest expectation.
    task check_result(out_item_t r);
      out_item_t e;
      if (pending.size() == 0) begin
        report("unexpected item", {32'd0, r.pressure_hpa}, 64'd0);
        return;
      end
      e = pending.pop_front();
      if (r.result_kind !== e.result_kind)
        report("result_kind", {63'd0, r.result_kind}, {63'd0, e.result_kind});
      if (r.temperature_centi !== e.temperature_centi)
        report("temperature_centi", {32'd0, r.temperature_centi},
               {32'd0, e.temperature_centi});
      if (r.pressure_hpa !== e.pressure_hpa)
        report("pressure_hpa", {32'd0, r.pressure_hpa}, {32'd0, e.pressure_hpa});
      if (r.divisor_zero !== e.divisor_zero)
        report("divisor_zero", {63'd0, r.divisor_zero}, {63'd0, e.divisor_zero});
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  comp_scoreboard sb = new();
  bit rx_hold_req = 1'b0;   // ask the receiver for one long stall
  bit no_idle = 1'b0;       // stretches with neither side idling

  baro_sensor_compensation_core dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Watch both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(200, 30);
  endfunction

  // Receiver: random stalls, plus one long hold while the sender keeps going.
  initial begin
    int n;
    forever begin
      if (rx_hold_req) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (2000) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      repeat ($urandom_range(20)) @(negedge clk_i);
    end
  end

  // Offer one item; hold valid and payload until accepted, then maybe idle.
  task send_item(in_item_t it);
    int g;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  function automatic in_item_t make_item(logic kind, logic [19:0] adc);
    in_item_t it;
    it.kind        = kind;
    it.sample_msb  = adc[19:12];
    it.sample_lsb  = adc[11:4];
    it.sample_xlsb = {adc[3:0], 4'($urandom)};
    return it;
  endfunction

  // Random item: mostly adc values in the sensor's usual band, some anywhere.
  function automatic in_item_t rand_item();
    logic [19:0] adc;
    if ($urandom_range(3) == 0) adc = 20'($urandom);
    else adc = 20'($urandom_range(20'h9_0000, 20'h4_0000));
    return make_item(1'($urandom), adc);
  endfunction

  // Drop valid, drain, then write all four registers while the block is idle.
  task load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] pm, logic [63:0] p9);
    logic [63:0] v [4];
    v = '{tc, pl, pm, p9};
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (20) @(posedge clk_i);
    foreach (v[i]) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= v[i];
      sb.write_cal(2'(i), v[i]);
    end
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task run_random(int count);
    repeat (count) send_item(rand_item());
  endtask

  // Vendor-like calibration set
  localparam logic [63:0] TCAL_TYP = {16'h0, 16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] PLOW_TYP = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] PMID_TYP = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] P9_TYP   = 64'd6000;

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    load_cal(TCAL_TYP, PLOW_TYP, PMID_TYP, P9_TYP);
    // Pressure before any temperature uses the reset fine temperature.
    send_item(make_item(KIND_PRESS, 20'h6_5A00));
    send_item(make_item(KIND_TEMP, 20'h8_2000));
    send_item(make_item(KIND_PRESS, 20'h6_5A00));
    // Byte extremes for both kinds
    for (int k = 0; k < 2; k++) begin
      send_item('{kind: 1'(k), sample_msb: 8'h00, sample_lsb: 8'h00, sample_xlsb: 8'h00});
      send_item('{kind: 1'(k), sample_msb: 8'hFF, sample_lsb: 8'hFF, sample_xlsb: 8'hFF});
      send_item('{kind: 1'(k), sample_msb: 8'hFF, sample_lsb: 8'h00, sample_xlsb: 8'h0F});
      send_item('{kind: 1'(k), sample_msb: 8'h00, sample_lsb: 8'hFF, sample_xlsb: 8'hF0});
      send_item('{kind: 1'(k), sample_msb: 8'h80, sample_lsb: 8'h00, sample_xlsb: 8'h00});
    end
    send_item(make_item(KIND_TEMP, 20'h7_E000));
    send_item(make_item(KIND_PRESS, 20'h5_0000));

    // Zero calibration: every pressure divisor is zero.
    load_cal('0, '0, '0, '0);
    run_random(60);

    // All ones: signed halfwords of -1 and largest unsigned ones.
    load_cal('1, '1, '1, '1);
    run_random(100);

    // Extremes mixed: largest P1/T1, most negative or largest signed terms.
    load_cal({16'h0, 16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
             {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 64'h8000);
    run_random(100);

    // Typical calibration: long receiver hold so the queue fills, then a burst.
    load_cal(TCAL_TYP, PLOW_TYP, PMID_TYP, P9_TYP);
    rx_hold_req = 1'b1;
    run_random(300);
    no_idle = 1'b1;
    run_random(200);
    no_idle = 1'b0;
    run_random(300);

    // Random calibration words
    repeat (5) begin
      load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
      run_random(200);
    end

    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d temperature and %0d pressure items, %0d with a zero divisor,",
             sb.n_temp, sb.n_press, sb.n_zero);
    $display("over zero, all-ones, extreme, typical and random calibration sets");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up after a generous fixed time.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> baro_sensor_compensation_core.f
+incdir+hw/rtl
hw/rtl/baro_pkg.sv
hw/rtl/baro_front.sv
hw/rtl/baro_div.sv
hw/rtl/baro_back.sv
hw/rtl/baro_sensor_compensation_core.sv
tb/baro_sensor_compensation_core_test.sv
